// ===== hdl/ihv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 header validate package
// Shared constants and types for the IPv4 header validator.
// ----------------------------------------------------------------------------
package ihv_pkg;

  localparam int unsigned POS_W                 = 7;
  localparam logic [6:0]  POS_MAX               = 7'd127;
  localparam logic [6:0]  ETYPE_HI_POS          = 7'd12;
  localparam logic [6:0]  ETYPE_LO_POS          = 7'd13;
  localparam logic [6:0]  CKSUM_HI_OFS          = 7'd10;
  localparam logic [6:0]  CKSUM_LO_OFS          = 7'd11;
  localparam int unsigned FIELD_BYTES           = 20;
  localparam int unsigned LINK_HEADER_BYTES_DEF = 14;
  localparam logic [3:0]  MIN_IHL               = 4'd5;
  localparam logic [15:0] ETHERTYPE_IPV4        = 16'h0800;

  // One frame byte held in the input stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } item_t;

  // One validation result.
  typedef struct packed {
    logic        is_ipv4;
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [15:0] total_length;
    logic [15:0] identification;
    logic [15:0] flags_fragment;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_number;
    logic [15:0] header_checksum;
    logic [31:0] source_address;
    logic [31:0] destination_address;
  } result_t;

endpackage : ihv_pkg
`default_nettype wire

// ===== hdl/ihv_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 header validate input stage
// Registers one incoming frame byte and holds it while the tracker is blocked.
// ----------------------------------------------------------------------------
module ihv_in_stage
  import ihv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] frame_byte_i,
  input  wire logic       end_of_frame_i,
  input  wire logic       blocked_i,
  output item_t           item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       eof_q;
  logic       accept;

  assign in_stall_o = valid_q & blocked_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Drop the held byte once it advances, unless a new one replaces it.
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !blocked_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= frame_byte_i;
      eof_q  <= end_of_frame_i;
    end
  end

  assign item_o = '{valid: valid_q, frame_byte: byte_q, end_of_frame: eof_q};

endmodule : ihv_in_stage
`default_nettype wire

// ===== hdl/ihv_hdr_track.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 header validate frame tracker
// Per-frame state: position, EtherType match, captured header, checksum sum.
// ----------------------------------------------------------------------------
module ihv_hdr_track
  import ihv_pkg::*;
#(
  parameter int unsigned LinkHeaderBytes = LINK_HEADER_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        end_of_frame_i,
  input  wire logic [15:0] expected_ethertype_i,
  output result_t          result_o
);

  localparam logic [POS_W-1:0] LinkPos = POS_W'(LinkHeaderBytes);

  logic [POS_W-1:0] pos_q, pos_d, pos_n, ofs;
  logic             type_match_q, type_match_d, type_match_n;
  logic [7:0]       type_hi_q, type_hi_d;
  logic [7:0]       word_hi_q, word_hi_d;
  logic [15:0]      sum_q, sum_d, sum_n;
  logic [7:0]       hdr_q [FIELD_BYTES];
  logic [7:0]       hdr_d [FIELD_BYTES];
  logic [7:0]       hdr_n [FIELD_BYTES];
  logic             in_hdr, in_sum;
  logic [7:0]       sum_byte;
  logic [16:0]      sum_wide;
  logic [POS_W-1:0] hdr_len;
  logic             complete;

  assign ofs    = pos_q - LinkPos;
  assign in_hdr = (pos_q >= LinkPos) && (pos_q < POS_MAX);

  always_comb begin
    // Capture header bytes at their own offsets.
    for (int i = 0; i < FIELD_BYTES; i++) begin
      hdr_n[i] = hdr_q[i];
      if (in_hdr && ofs == POS_W'(i)) begin
        hdr_n[i] = frame_byte_i;
      end
    end

    // EtherType check.
    type_hi_d    = type_hi_q;
    type_match_n = type_match_q;
    if (pos_q == ETYPE_HI_POS) begin
      type_hi_d = frame_byte_i;
    end else if (pos_q == ETYPE_LO_POS) begin
      type_match_n = ({type_hi_q, frame_byte_i} == expected_ethertype_i);
    end

    // Checksum: header length comes from the freshly captured IHL.
    hdr_len  = {1'b0, hdr_n[0][3:0], 2'b00};
    in_sum   = in_hdr && (ofs < hdr_len);
    sum_byte = (ofs == CKSUM_HI_OFS || ofs == CKSUM_LO_OFS) ? 8'h00 : frame_byte_i;
    sum_wide = {1'b0, sum_q} + {1'b0, word_hi_q, sum_byte};
    word_hi_d = word_hi_q;
    sum_n     = sum_q;
    if (in_sum) begin
      if (!ofs[0]) begin
        word_hi_d = sum_byte;
      end else begin
        sum_n = sum_wide[15:0] + {15'd0, sum_wide[16]};
      end
    end

    pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

    // Clear all frame state after the last byte.
    if (end_of_frame_i) begin
      pos_d        = '0;
      type_match_d = 1'b0;
      type_hi_d    = '0;
      word_hi_d    = '0;
      sum_d        = '0;
      for (int i = 0; i < FIELD_BYTES; i++) begin
        hdr_d[i] = '0;
      end
    end else begin
      pos_d        = pos_n;
      type_match_d = type_match_n;
      sum_d        = sum_n;
      for (int i = 0; i < FIELD_BYTES; i++) begin
        hdr_d[i] = hdr_n[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      type_match_q <= 1'b0;
      type_hi_q    <= '0;
      word_hi_q    <= '0;
      sum_q        <= '0;
      for (int i = 0; i < FIELD_BYTES; i++) begin
        hdr_q[i] <= '0;
      end
    end else if (step_i) begin
      pos_q        <= pos_d;
      type_match_q <= type_match_d;
      type_hi_q    <= type_hi_d;
      word_hi_q    <= word_hi_d;
      sum_q        <= sum_d;
      for (int i = 0; i < FIELD_BYTES; i++) begin
        hdr_q[i] <= hdr_d[i];
      end
    end
  end

  assign complete = (pos_n >= LinkPos + {1'b0, hdr_n[0][3:0], 2'b00});

  always_comb begin
    result_o.version             = hdr_n[0][7:4];
    result_o.header_words        = hdr_n[0][3:0];
    result_o.service_type        = hdr_n[1];
    result_o.total_length        = {hdr_n[2], hdr_n[3]};
    result_o.identification      = {hdr_n[4], hdr_n[5]};
    result_o.flags_fragment      = {hdr_n[6], hdr_n[7]};
    result_o.time_to_live        = hdr_n[8];
    result_o.protocol_number     = hdr_n[9];
    result_o.header_checksum     = {hdr_n[10], hdr_n[11]};
    result_o.source_address      = {hdr_n[12], hdr_n[13], hdr_n[14], hdr_n[15]};
    result_o.destination_address = {hdr_n[16], hdr_n[17], hdr_n[18], hdr_n[19]};
    result_o.is_ipv4             = type_match_n && (hdr_n[0][3:0] >= MIN_IHL) && complete
                                   && ({hdr_n[10], hdr_n[11]} == ~sum_n);
  end

endmodule : ihv_hdr_track
`default_nettype wire

// ===== hdl/ihv_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 header validate output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ihv_out_reg
  import ihv_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  result_t      result_i,
  input  wire logic    out_stall_i,
  output logic         out_valid_o,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule : ihv_out_reg
`default_nettype wire

// ===== hdl/ipv4_header_validate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The last byte is registered in the input stage, its result in the output register.
// Throughput: one frame byte per cycle unless stalled; a byte is taken while a result waits.
// The input stalls only when a last byte is held and the result register is full.
// Reset (rst_ni low, asynchronous) clears frame state, empties both stages and
// restores the expected EtherType to 0x0800.
// ----------------------------------------------------------------------------
// IPv4 header validate
// Checks EtherType, IHL and header checksum of an Ethernet frame streamed one
// byte per transaction, and reports the captured IPv4 header fields.
// ----------------------------------------------------------------------------
module ipv4_header_validate
  import ihv_pkg::*;
#(
  parameter int unsigned LinkHeaderBytes = LINK_HEADER_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // frame byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        end_of_frame_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_ipv4_o,
  output logic [3:0]       version_o,
  output logic [3:0]       header_words_o,
  output logic [7:0]       service_type_o,
  output logic [15:0]      total_length_o,
  output logic [15:0]      identification_o,
  output logic [15:0]      flags_fragment_o,
  output logic [7:0]       time_to_live_o,
  output logic [7:0]       protocol_number_o,
  output logic [15:0]      header_checksum_o,
  output logic [31:0]      source_address_o,
  output logic [31:0]      destination_address_o
);

  logic [15:0] ethertype_q;
  item_t       item;
  logic        blocked;
  logic        step;
  logic        res_load;
  result_t     res_next;
  result_t     res_out;

  // Configuration register: the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ethertype_q <= ETHERTYPE_IPV4;
    end else if (cfg_we_i) begin
      ethertype_q <= cfg_wdata_i;
    end
  end

  // Hold a last byte only when its result cannot enter the output register.
  assign blocked  = item.end_of_frame & out_valid_o & out_stall_i;
  assign step     = item.valid & ~blocked;
  assign res_load = step & item.end_of_frame;

  ihv_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_byte_i   (frame_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .blocked_i      (blocked),
    .item_o         (item)
  );

  // Advance the frame state by one byte per cycle while not blocked; the result is formed from
  // the state as updated by the last byte.
  ihv_hdr_track #(
    .LinkHeaderBytes (LinkHeaderBytes)
  ) u_hdr_track (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (step),
    .frame_byte_i         (item.frame_byte),
    .end_of_frame_i       (item.end_of_frame),
    .expected_ethertype_i (ethertype_q),
    .result_o             (res_next)
  );

  ihv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .result_i    (res_next),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (res_out)
  );

  assign is_ipv4_o             = res_out.is_ipv4;
  assign version_o             = res_out.version;
  assign header_words_o        = res_out.header_words;
  assign service_type_o        = res_out.service_type;
  assign total_length_o        = res_out.total_length;
  assign identification_o      = res_out.identification;
  assign flags_fragment_o      = res_out.flags_fragment;
  assign time_to_live_o        = res_out.time_to_live;
  assign protocol_number_o     = res_out.protocol_number;
  assign header_checksum_o     = res_out.header_checksum;
  assign source_address_o      = res_out.source_address;
  assign destination_address_o = res_out.destination_address;

  // A result never overwrites one that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a pending transaction");

  // Stall only comes from a held last byte.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item.valid && item.end_of_frame && out_valid_o))
    else $error("input stalled without a pending last byte");

  // A loaded result shows up on the next cycle.
  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_o)
    else $error("loaded result not presented");

  // A passing header always has at least five words.
  a_ihl_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_ipv4_o) |-> (header_words_o >= MIN_IHL))
    else $error("valid flag set with short header");

endmodule : ipv4_header_validate
`default_nettype wire

// ===== tb/ipv4_header_validate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header validate testbench
// Streams Ethernet frames into the validator one byte per transaction and
// checks every result against an in-bench model of the EtherType, IHL and
// header checksum logic. Directed frames cover field extremes, failed checks,
// truncated and oversized frames and EtherType settings; random traffic then
// runs under three sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module ipv4_header_validate_tb;
  import ihv_pkg::*;

  localparam int LINK_BYTES   = LINK_HEADER_BYTES_DEF;
  localparam int MAX_HDR      = 60;      // IHL 15 in bytes
  localparam int DRAIN_CYCLES = 8;       // margin for a result to pass the input and output registers
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BYTES = 270;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  // Clock, reset and block-facing signals; every input starts at a known value.
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  frame_byte  = '0;
  logic        end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        is_ipv4;
  logic [3:0]  version;
  logic [3:0]  header_words;
  logic [7:0]  service_type;
  logic [15:0] total_length;
  logic [15:0] identification;
  logic [15:0] flags_fragment;
  logic [7:0]  time_to_live;
  logic [7:0]  protocol_number;
  logic [15:0] header_checksum;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  // Idle rates in percent; the random phases change them.
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 66;

  // Stimulus scratch: the IPv4 header of the next frame.
  logic [7:0] ip_hdr [MAX_HDR];

  // Header model state, mirrors what the block keeps per frame.
  logic [15:0] cur_ethertype = ETHERTYPE_IPV4;
  logic [6:0]  link_pos      = '0;
  logic        type_ok       = 1'b0;
  logic [7:0]  type_hi       = '0;
  logic [7:0]  pair_hi       = '0;
  logic [15:0] hdr_sum       = '0;
  logic [63:0] hdr_cap [3]   = '{default: '0};

  result_t pending_results [$];

  int errors      = 0;
  int bytes_sent  = 0;
  int frames_sent = 0;
  int cycle_count = 0;

  ipv4_header_validate #(
    .LinkHeaderBytes(LINK_BYTES)
  ) dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .frame_byte_i          (frame_byte),
    .end_of_frame_i        (end_of_frame),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .is_ipv4_o             (is_ipv4),
    .version_o             (version),
    .header_words_o        (header_words),
    .service_type_o        (service_type),
    .total_length_o        (total_length),
    .identification_o      (identification),
    .flags_fragment_o      (flags_fragment),
    .time_to_live_o        (time_to_live),
    .protocol_number_o     (protocol_number),
    .header_checksum_o     (header_checksum),
    .source_address_o      (source_address),
    .destination_address_o (destination_address)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost result ends up here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ipv4_header_validate verification failed");
    $finish;
  end

  // Receiver: stall at random, independent of out_valid.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // 16-bit ones'-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = acc + word;
    return s[15:0] + s[16];
  endfunction

  function automatic int header_len();
    return int'(ip_hdr[0][3:0]) * 4;
  endfunction

  // --------------------------------------------------------------------------
  // Header model: advance the per-frame state by one accepted byte and, on the
  // last byte, queue the result the block must produce, then clear the frame.
  // --------------------------------------------------------------------------
  task automatic predict_byte(input logic [7:0] value, input logic last);
    int         ofs;
    int         hdr_len;
    logic [7:0] sum_byte;
    result_t    r;
    // EtherType sits at link bytes 12 and 13; compare on the low byte.
    if (link_pos == ETYPE_HI_POS) type_hi = value;
    else if (link_pos == ETYPE_LO_POS) type_ok = ({type_hi, value} == cur_ethertype);

    // Past the link header and short of saturation: capture and sum.
    if (int'(link_pos) >= LINK_BYTES && link_pos < POS_MAX) begin
      ofs = int'(link_pos) - LINK_BYTES;
      if (ofs < 16) hdr_cap[ofs / 8][8 * (7 - ofs % 8) +: 8] = value;
      else if (ofs < FIELD_BYTES) hdr_cap[2][8 * (19 - ofs) +: 8] = value;
      // IHL comes from the byte just captured when ofs is 0.
      hdr_len = int'(hdr_cap[0][59:56]) * 4;
      if (ofs < hdr_len) begin
        // Count the stored checksum word as zero.
        sum_byte = (ofs == CKSUM_HI_OFS || ofs == CKSUM_LO_OFS) ? 8'h00 : value;
        if (ofs % 2 == 0) pair_hi = sum_byte;
        else hdr_sum = ones_add(hdr_sum, {pair_hi, sum_byte});
      end
    end
    if (link_pos < POS_MAX) link_pos++;

    if (last) begin
      hdr_len = int'(hdr_cap[0][59:56]) * 4;
      // Valid only with a type match, IHL of 5 or more, the whole header seen
      // and the stored checksum equal to the complement of the sum.
      r.is_ipv4 = type_ok && (hdr_cap[0][59:56] >= MIN_IHL)
                  && (int'(link_pos) >= LINK_BYTES + hdr_len)
                  && (hdr_cap[1][47:32] == ~hdr_sum);
      r.version             = hdr_cap[0][63:60];
      r.header_words        = hdr_cap[0][59:56];
      r.service_type        = hdr_cap[0][55:48];
      r.total_length        = hdr_cap[0][47:32];
      r.identification      = hdr_cap[0][31:16];
      r.flags_fragment      = hdr_cap[0][15:0];
      r.time_to_live        = hdr_cap[1][63:56];
      r.protocol_number     = hdr_cap[1][55:48];
      r.header_checksum     = hdr_cap[1][47:32];
      r.source_address      = hdr_cap[1][31:0];
      r.destination_address = hdr_cap[2][31:0];
      pending_results.push_back(r);
      link_pos = '0;
      type_ok  = 1'b0;
      type_hi  = '0;
      pair_hi  = '0;
      hdr_sum  = '0;
      hdr_cap  = '{default: '0};
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: sample at the falling edge, so the transaction taken at the
  // next rising edge is seen with settled values, and compare field by field
  // against the oldest queued result.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got is_ipv4 %0b src %0h",
                 $time, is_ipv4, source_address);
      end else begin
        want = pending_results.pop_front();
        check_field("is_ipv4", want.is_ipv4, is_ipv4);
        check_field("version", want.version, version);
        check_field("header_words", want.header_words, header_words);
        check_field("service_type", want.service_type, service_type);
        check_field("total_length", want.total_length, total_length);
        check_field("identification", want.identification, identification);
        check_field("flags_fragment", want.flags_fragment, flags_fragment);
        check_field("time_to_live", want.time_to_live, time_to_live);
        check_field("protocol_number", want.protocol_number, protocol_number);
        check_field("header_checksum", want.header_checksum, header_checksum);
        check_field("source_address", want.source_address, source_address);
        check_field("destination_address", want.destination_address,
                    destination_address);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Called and returns at a rising edge. Leave valid high after the
  // transaction so back-to-back bytes run without a bubble; drop it only in an
  // idle cycle or in settle.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    frame_byte   <= value;
    end_of_frame <= last;
    // Stall is stable from the falling edge on; low there means taken next edge.
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_byte(value, last);
    bytes_sent++;
  endtask

  // Frame layout: random MAC addresses, EtherType, ip_hdr, random payload.
  task automatic send_frame(input logic [15:0] etype, input int frame_len);
    logic [7:0] b;
    for (int i = 0; i < frame_len; i++) begin
      if (i == ETYPE_HI_POS) b = etype[15:8];
      else if (i == ETYPE_LO_POS) b = etype[7:0];
      else if (i >= LINK_BYTES && i < LINK_BYTES + MAX_HDR) b = ip_hdr[i - LINK_BYTES];
      else b = 8'($urandom_range(255));
      send_byte(b, i == frame_len - 1);
    end
    frames_sent++;
  endtask

  task automatic fill_header(input logic [3:0] ver, input logic [3:0] ihl, input fill_e pattern);
    for (int i = 1; i < MAX_HDR; i++) begin
      case (pattern)
        FILL_ZERO: ip_hdr[i] = 8'h00;
        FILL_ONES: ip_hdr[i] = 8'hFF;
        default:   ip_hdr[i] = 8'($urandom_range(255));
      endcase
    end
    ip_hdr[0] = {ver, ihl};
  endtask

  // Write a correct checksum over the IHL-sized header.
  task automatic seal_checksum();
    logic [15:0] acc;
    int          n;
    acc = '0;
    n   = header_len();
    for (int i = 0; i + 1 < n; i += 2) begin
      if (i != int'(CKSUM_HI_OFS)) acc = ones_add(acc, {ip_hdr[i], ip_hdr[i + 1]});
    end
    ip_hdr[CKSUM_HI_OFS] = ~acc[15:8];
    ip_hdr[CKSUM_LO_OFS] = ~acc[7:0];
  endtask

  // Drop valid and drain every outstanding result; the block is idle after.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ethertype(input logic [15:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    cur_ethertype  = value;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Reset value of the EtherType register must accept a plain IPv4 frame.
  task automatic test_default_ethertype();
    fill_header(4'd4, 4'd5, FILL_RANDOM);
    seal_checksum();
    send_frame(ETHERTYPE_IPV4, LINK_BYTES + 20);
    fill_header(4'd4, 4'd5, FILL_RANDOM);
    seal_checksum();
    send_frame(ETHERTYPE_IPV4, LINK_BYTES + 20 + 6);
  endtask

  // All-ones and all-zero headers, longest header with options.
  task automatic test_field_extremes();
    fill_header(4'hF, 4'hF, FILL_ONES);
    send_frame(cur_ethertype, LINK_BYTES + MAX_HDR);
    fill_header(4'hF, 4'hF, FILL_ONES);
    seal_checksum();
    send_frame(cur_ethertype, LINK_BYTES + MAX_HDR + 3);
    fill_header(4'h0, 4'd5, FILL_ZERO);
    seal_checksum();
    send_frame(cur_ethertype, LINK_BYTES + 20);
    fill_header(4'd4, 4'hF, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype, LINK_BYTES + MAX_HDR + 10);
  endtask

  // Failed checks still report the captured fields.
  task automatic test_failed_checks();
    fill_header(4'd4, 4'd5, FILL_RANDOM);
    seal_checksum();
    ip_hdr[CKSUM_LO_OFS] = ip_hdr[CKSUM_LO_OFS] ^ 8'h01;
    send_frame(cur_ethertype, LINK_BYTES + 20);
    fill_header(4'd4, 4'd5, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype ^ 16'h8000, LINK_BYTES + 20);
    fill_header(4'd4, 4'd4, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype, LINK_BYTES + 20);
    fill_header(4'd4, 4'd0, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype, LINK_BYTES + 20);
  endtask

  // Frames that end before the header is complete; missing bytes read zero.
  task automatic test_short_frames();
    fill_header(4'd4, 4'd5, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype, 1);
    send_frame(cur_ethertype, ETYPE_LO_POS);
    send_frame(cur_ethertype, LINK_BYTES);
    send_frame(cur_ethertype, LINK_BYTES + 19);
    fill_header(4'd4, 4'd6, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype, LINK_BYTES + 23);
  endtask

  // Frames at and past the saturation point of the position counter.
  task automatic test_long_frames();
    fill_header(4'd4, 4'd5, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype, POS_MAX);
    send_frame(cur_ethertype, POS_MAX + 1);
    fill_header(4'd4, 4'hF, FILL_RANDOM);
    seal_checksum();
    send_frame(cur_ethertype, 150);
  endtask

  // EtherType register at both ends of its range, then back to IPv4.
  task automatic test_ethertype_extremes();
    write_ethertype(16'h0000);
    fill_header(4'd4, 4'd5, FILL_RANDOM);
    seal_checksum();
    send_frame(16'h0000, LINK_BYTES + 20);
    send_frame(ETHERTYPE_IPV4, LINK_BYTES + 20);
    write_ethertype(16'hFFFF);
    send_frame(16'hFFFF, LINK_BYTES + 20 + 2);
    send_frame(ETHERTYPE_IPV4, LINK_BYTES + 20);
    write_ethertype(ETHERTYPE_IPV4);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly well-formed frames with random content, the rest
  // corrupted checksums, wrong EtherTypes, short IHLs, truncated and long frames.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [15:0] etype_setting, input int byte_budget);
    int          start_bytes;
    int unsigned pick;
    logic [3:0]  ihl;
    logic [3:0]  ver;
    logic [15:0] etype;
    int          hlen;
    int          frame_len;
    int          idx;
    write_ethertype(etype_setting);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_bytes   = bytes_sent;
    while (bytes_sent - start_bytes < byte_budget) begin
      pick  = $urandom_range(99);
      ihl   = $urandom_range(1) ? 4'd5 : 4'($urandom_range(5, 15));
      ver   = ($urandom_range(9) != 0) ? 4'd4 : 4'($urandom_range(15));
      etype = cur_ethertype;
      if (pick >= 85 && pick < 90) ihl = 4'($urandom_range(4));
      fill_header(ver, ihl, FILL_RANDOM);
      seal_checksum();
      hlen      = header_len();
      frame_len = LINK_BYTES + hlen + int'($urandom_range(6));
      if (pick < 4) begin
        // Long frame: run the position counter into saturation.
        frame_len = $urandom_range(128, 150);
      end else if (pick >= 78 && pick < 85) begin
        // Corrupt one header bit past the version/IHL byte.
        idx = $urandom_range(1, hlen - 1);
        ip_hdr[idx] = ip_hdr[idx] ^ (8'h01 << $urandom_range(7));
      end else if (pick >= 90 && pick < 95) begin
        etype = cur_ethertype ^ (16'h0001 << $urandom_range(15));
      end else if (pick >= 95) begin
        frame_len = $urandom_range(1, LINK_BYTES + hlen - 1);
      end
      send_frame(etype, frame_len);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_ethertype();
    test_field_extremes();
    test_failed_checks();
    test_short_frames();
    test_long_frames();
    test_ethertype_extremes();

    test_random_traffic(21, 66, 16'($urandom_range(65535)), RANDOM_BYTES / 3);
    test_random_traffic(66, 21, 16'hFFFF, RANDOM_BYTES / 3);
    test_random_traffic(0, 0, ETHERTYPE_IPV4, RANDOM_BYTES - 2 * (RANDOM_BYTES / 3));

    // Drain and let any stray result surface before the verdict.
    settle();
    if (errors == 0) begin
      $display("ipv4_header_validate verification clean");
    end else begin
      $display("ipv4_header_validate verification failed");
    end
    $finish;
  end

endmodule
